FILE: hdl/ott_pkg.sv
// shared types, constants and helpers for the obstacle track table
`timescale 1ns / 1ps
package ott_pkg;

  localparam int MAX_TRACKS  = 16;
  localparam int MAX_HORIZON = 255;
  localparam int IDX_W       = $clog2(MAX_TRACKS);
  localparam int CNT_W       = $clog2(MAX_TRACKS + 1);
  localparam int POS_W       = 24;
  localparam int TIME_W      = 32;
  localparam int RAD_W       = 16;
  localparam int MUL_W       = 26;
  localparam int DIV_W       = 48;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int MS_PER_S    = 1000;
  localparam int RAD_MIN     = 256;
  // divide by 1000 in 16-bit digits: quotient digit = (t * ceil(2^36 / 1000)) >> 36
  localparam int MS_DIG_W    = 16;
  localparam int MS_DIGITS   = DIV_W / MS_DIG_W;
  localparam logic [26:0] MS_RECIP = 27'd68719477;

  typedef enum logic [1:0] {
    REQ_OBS   = 2'd0,
    REQ_PRUNE = 2'd1,
    REQ_PRED  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    RK_OBS   = 2'd0,
    RK_PRUNE = 2'd1,
    RK_TRACK = 2'd2,
    RK_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_UPD  = 2'd0,
    ST_INS  = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MERGE = 2'd0,
    CFG_STALE = 2'd1,
    CFG_STEP  = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_OBS_MD, S_OBS_MDW, S_OBS_DX, S_OBS_DY, S_OBS_CMP, S_OBS_END, S_OBS_FIN,
    S_PRN_SCAN, S_PRN_FIN,
    S_PRD_START, S_PRD_SPAN, S_PRD_EMPTY,
    S_PRD_VX, S_PRD_VXD, S_PRD_VXW, S_PRD_VYD, S_PRD_VYW,
    S_PRD_PX, S_PRD_PXD, S_PRD_PXW, S_PRD_PYD, S_PRD_PYW, S_PRD_EMIT
  } state_t;

  // one table slot
  typedef struct packed {
    logic [POS_W-1:0]  cur_x;
    logic [POS_W-1:0]  cur_y;
    logic [POS_W-1:0]  prev_x;
    logic [POS_W-1:0]  prev_y;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] prev_time;
    logic [RAD_W-1:0]  radius;
    logic              hist;
  } entry_t;

  // saturate a 50-bit two's complement value to 24 bits
  function automatic logic [POS_W-1:0] sat24(input logic [49:0] v);
    logic [POS_W-1:0] r;
    if (!v[49] && (|v[48:POS_W-1])) r = {1'b0, {(POS_W-1){1'b1}}};
    else if (v[49] && !(&v[48:POS_W-1])) r = {1'b1, {(POS_W-1){1'b0}}};
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/ott_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module ott_mul
  import ott_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p
);

  // product register
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hdl/ott_div.sv
// iterative signed divider: one quotient bit per cycle, or 16-bit digits for the ms scale
`timescale 1ns / 1ps
module ott_div
  import ott_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             by_ms,
  input  logic [DIV_W:0]   num,
  input  logic [31:0]      den,
  output logic             busy,
  output logic             done,
  output logic [DIV_W:0]   quo
);

  logic                 neg;
  logic                 ms_mode;
  logic [DIV_W-1:0]     mag;
  logic [31:0]          rem;
  logic [31:0]          dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       num_abs;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic [32:0]          rem_sub;
  logic [25:0]          kt;
  logic [51:0]          kp;
  logic [MS_DIG_W-1:0]  kq;
  logic [9:0]           kr;

  // restoring step
  assign num_abs = num[DIV_W] ? (~num + 1'b1) : num;
  assign rem_sh  = {rem, mag[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign quo     = neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};

  // divide by 1000: one 16-bit digit per step by reciprocal multiply
  assign kt = {rem[9:0], mag[DIV_W-1 -: MS_DIG_W]};
  assign kp = 52'(kt) * 52'(MS_RECIP);
  assign kq = kp[51:36];
  assign kr = 10'(kt - 26'(kq) * 26'(MS_PER_S));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= by_ms ? DIV_CNT_W'(MS_DIGITS) : DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[DIV_W];
      ms_mode <= by_ms;
      mag     <= num_abs[DIV_W-1:0];
      rem     <= '0;
      dsr     <= den;
    end else if (busy) begin
      if (ms_mode) begin
        rem <= {22'b0, kr};
        mag <= {mag[DIV_W-MS_DIG_W-1:0], kq};
      end else begin
        rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        mag <= {mag[DIV_W-2:0], ge};
      end
    end
  end

endmodule

FILE: hdl/ott_table.sv
// track table storage, one write and one read port
`timescale 1ns / 1ps
module ott_table
  import ott_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] wa,
  input  entry_t           wd,
  input  logic [IDX_W-1:0] ra,
  output entry_t           rd
);

  entry_t slots [MAX_TRACKS];

  // slot write
  always_ff @(posedge clk) begin
    if (we) begin
      slots[wa] <= wd;
    end
  end

  assign rd = slots[ra];

endmodule

FILE: hdl/obstacle_track_table_unit.sv
// obstacle track table: sequencer around a shared multiplier and divider
// observe: squares the merge distance, then squares dx and dy per scanned track and compares
// prune: compacts the kept tracks in place; predict: two velocity divisions by dt per track
// with history, then two of velocity times span by 1000; zero velocity without history
// one request at a time; result stalls hold the sequencer, the result register frees it
// sync reset clears track count and handshakes, sets config defaults; slots undefined until written
`timescale 1ns / 1ps
module obstacle_track_table_unit
  import ott_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_type,
  input  logic [POS_W-1:0]  obs_x,
  input  logic [POS_W-1:0]  obs_y,
  input  logic [RAD_W-1:0]  obs_radius,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [7:0]        horizon_step,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [1:0]        result_kind,
  output logic [1:0]        obs_status,
  output logic [IDX_W-1:0]  slot_index,
  output logic [CNT_W-1:0]  live_count,
  output logic [POS_W-1:0]  pred_x,
  output logic [POS_W-1:0]  pred_y,
  output logic [POS_W-1:0]  vel_x,
  output logic [POS_W-1:0]  vel_y,
  output logic [RAD_W-1:0]  track_radius,
  output logic              last
);

  state_t state, state_next;

  logic [15:0]       merge_distance, stale_timeout_ms, step_ms;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx, wptr;
  logic [POS_W-1:0]  ox, oy;
  logic [RAD_W-1:0]  orad;
  logic [TIME_W-1:0] onow;
  logic [7:0]        oh;
  logic [31:0]       md2;
  logic [48:0]       d2a;
  logic [23:0]       span;
  logic [POS_W-1:0]  vx, vy, px, py;
  logic [1:0]        st_status;
  logic [IDX_W-1:0]  st_slot;

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] mp;
  logic                      div_start, div_ms, div_busy, div_done;
  logic [DIV_W:0]            div_num, div_q;
  logic [31:0]               div_den;
  logic                      tbl_we;
  logic [IDX_W-1:0]          tbl_wa;
  entry_t                    tbl_wd, e;
  logic                      res_load;

  logic              accept, out_free, scan_end, full, hit, keep, trk_last;
  logic [24:0]       dx, dy, ddx, ddy;
  logic [TIME_W-1:0] dt_raw, dt, age;
  logic [49:0]       d2;
  logic [RAD_W-1:0]  rad_cl;
  logic [7:0]        h_cl;

  // shared units
  ott_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  ott_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .by_ms(div_ms), .num(div_num),
    .den(div_den), .busy(div_busy), .done(div_done), .quo(div_q)
  );

  ott_table u_tbl (
    .clk(clk), .we(tbl_we), .wa(tbl_wa), .wd(tbl_wd), .ra(idx[IDX_W-1:0]), .rd(e)
  );

  // handshake and status terms
  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;
  assign scan_end  = idx >= count;
  assign full      = count >= CNT_W'(MAX_TRACKS);
  assign trk_last  = (idx + 1'b1) == count;
  assign rad_cl    = (obs_radius < RAD_W'(RAD_MIN)) ? RAD_W'(RAD_MIN) : obs_radius;
  assign h_cl      = (horizon_step > 8'(MAX_HORIZON)) ? 8'(MAX_HORIZON) : horizon_step;

  // distance, velocity and age terms of the slot under the scan pointer
  assign dx     = {e.cur_x[POS_W-1], e.cur_x} - {ox[POS_W-1], ox};
  assign dy     = {e.cur_y[POS_W-1], e.cur_y} - {oy[POS_W-1], oy};
  assign ddx    = {e.cur_x[POS_W-1], e.cur_x} - {e.prev_x[POS_W-1], e.prev_x};
  assign ddy    = {e.cur_y[POS_W-1], e.cur_y} - {e.prev_y[POS_W-1], e.prev_y};
  assign d2     = {1'b0, d2a} + {1'b0, mp[48:0]};
  assign hit    = d2 < {18'b0, md2};
  assign dt_raw = e.cur_time - e.prev_time;
  assign dt     = (dt_raw[31] || dt_raw == '0) ? 32'd1 : dt_raw;
  assign age    = onow - e.cur_time;
  assign keep   = age[31] || (age[30:0] <= {15'b0, stale_timeout_ms});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_OBS:   state_next = S_OBS_MD;
            REQ_PRUNE: state_next = S_PRN_SCAN;
            REQ_PRED:  state_next = S_PRD_START;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_OBS_MD:    state_next = S_OBS_MDW;
      S_OBS_MDW:   state_next = S_OBS_DX;
      S_OBS_DX:    state_next = scan_end ? S_OBS_END : S_OBS_DY;
      S_OBS_DY:    state_next = S_OBS_CMP;
      S_OBS_CMP:   state_next = hit ? S_OBS_FIN : S_OBS_DX;
      S_OBS_END:   state_next = S_OBS_FIN;
      S_OBS_FIN:   if (out_free) state_next = S_IDLE;
      S_PRN_SCAN:  if (scan_end) state_next = S_PRN_FIN;
      S_PRN_FIN:   if (out_free) state_next = S_IDLE;
      S_PRD_START: state_next = S_PRD_SPAN;
      S_PRD_SPAN:  state_next = (count == '0) ? S_PRD_EMPTY : S_PRD_VX;
      S_PRD_EMPTY: if (out_free) state_next = S_IDLE;
      S_PRD_VX:    state_next = e.hist ? S_PRD_VXD : S_PRD_PX;
      S_PRD_VXD:   state_next = S_PRD_VXW;
      S_PRD_VXW:   if (div_done) state_next = S_PRD_VYD;
      S_PRD_VYD:   state_next = S_PRD_VYW;
      S_PRD_VYW:   if (div_done) state_next = S_PRD_PX;
      S_PRD_PX:    state_next = S_PRD_PXD;
      S_PRD_PXD:   state_next = S_PRD_PXW;
      S_PRD_PXW:   if (div_done) state_next = S_PRD_PYD;
      S_PRD_PYD:   state_next = S_PRD_PYW;
      S_PRD_PYW:   if (div_done) state_next = S_PRD_EMIT;
      S_PRD_EMIT:  if (out_free) state_next = trk_last ? S_IDLE : S_PRD_VX;
      default:     state_next = S_IDLE;
    endcase
  end

  // unit operands, table writes and result loads
  always_comb begin
    ma        = '0;
    mb        = '0;
    div_start = 1'b0;
    div_ms    = 1'b0;
    div_num   = mp[DIV_W:0];
    div_den   = dt;
    tbl_we    = 1'b0;
    tbl_wa    = idx[IDX_W-1:0];
    tbl_wd    = e;
    res_load  = 1'b0;
    case (state)
      S_OBS_MD: begin
        ma = $signed({10'b0, merge_distance});
        mb = $signed({10'b0, merge_distance});
      end
      S_OBS_DX: begin
        ma = $signed({dx[24], dx});
        mb = $signed({dx[24], dx});
      end
      S_OBS_DY: begin
        ma = $signed({dy[24], dy});
        mb = $signed({dy[24], dy});
      end
      S_OBS_CMP: begin
        if (hit) begin
          tbl_we           = 1'b1;
          tbl_wd.prev_x    = e.cur_x;
          tbl_wd.prev_y    = e.cur_y;
          tbl_wd.prev_time = e.cur_time;
          tbl_wd.cur_x     = ox;
          tbl_wd.cur_y     = oy;
          tbl_wd.cur_time  = onow;
          tbl_wd.radius    = orad;
          tbl_wd.hist      = 1'b1;
        end
      end
      S_OBS_END: begin
        tbl_we = !full;
        tbl_wa = count[IDX_W-1:0];
        tbl_wd = '{cur_x: ox, cur_y: oy, prev_x: ox, prev_y: oy, cur_time: onow,
                   prev_time: onow, radius: orad, hist: 1'b0};
      end
      S_PRN_SCAN: begin
        tbl_we = !scan_end && keep;
        tbl_wa = wptr[IDX_W-1:0];
      end
      S_PRD_START: begin
        ma = $signed({18'b0, oh});
        mb = $signed({10'b0, step_ms});
      end
      S_PRD_VX: begin
        ma = $signed({ddx[24], ddx});
        mb = MUL_W'(MS_PER_S);
      end
      S_PRD_VXD: div_start = 1'b1;
      S_PRD_VXW: begin
        ma = $signed({ddy[24], ddy});
        mb = MUL_W'(MS_PER_S);
      end
      S_PRD_VYD: div_start = 1'b1;
      S_PRD_PX: begin
        ma = $signed({{2{vx[POS_W-1]}}, vx});
        mb = $signed({2'b0, span});
      end
      S_PRD_PXD: begin
        div_start = 1'b1;
        div_ms    = 1'b1;
      end
      S_PRD_PXW: begin
        ma = $signed({{2{vy[POS_W-1]}}, vy});
        mb = $signed({2'b0, span});
      end
      S_PRD_PYD: begin
        div_start = 1'b1;
        div_ms    = 1'b1;
      end
      S_OBS_FIN, S_PRN_FIN, S_PRD_EMPTY, S_PRD_EMIT: res_load = out_free;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      res_valid        <= 1'b0;
      merge_distance   <= 16'd1024;
      stale_timeout_ms <= 16'd1500;
      step_ms          <= 16'd100;
    end else begin
      state <= state_next;
      if (state == S_OBS_END && !full) count <= count + 1'b1;
      if (state == S_PRN_SCAN && scan_end) count <= wptr;
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MERGE: merge_distance   <= cfg_data;
          CFG_STALE: stale_timeout_ms <= cfg_data;
          CFG_STEP:  step_ms          <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ox   <= obs_x;
        oy   <= obs_y;
        orad <= rad_cl;
        onow <= now_ms;
        oh   <= h_cl;
        idx  <= '0;
        wptr <= '0;
      end
      S_OBS_MDW: md2 <= mp[31:0];
      S_OBS_DY:  d2a <= mp[48:0];
      S_OBS_CMP: begin
        if (hit) begin
          st_status <= ST_UPD;
          st_slot   <= idx[IDX_W-1:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_OBS_END: begin
        st_status <= full ? ST_DROP : ST_INS;
        st_slot   <= full ? '0 : count[IDX_W-1:0];
      end
      S_PRN_SCAN: begin
        if (!scan_end) begin
          idx <= idx + 1'b1;
          if (keep) wptr <= wptr + 1'b1;
        end
      end
      S_PRD_SPAN: begin
        span <= mp[23:0];
        idx  <= '0;
      end
      S_PRD_VX: begin
        if (!e.hist) begin
          vx <= '0;
          vy <= '0;
        end
      end
      S_PRD_VXW: if (div_done) vx <= sat24({div_q[DIV_W], div_q});
      S_PRD_VYW: if (div_done) vy <= sat24({div_q[DIV_W], div_q});
      S_PRD_PXW: begin
        if (div_done) px <= sat24({{26{e.cur_x[POS_W-1]}}, e.cur_x} + {div_q[DIV_W], div_q});
      end
      S_PRD_PYW: begin
        if (div_done) py <= sat24({{26{e.cur_y[POS_W-1]}}, e.cur_y} + {div_q[DIV_W], div_q});
      end
      S_PRD_EMIT: if (out_free && !trk_last) idx <= idx + 1'b1;
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (res_load) begin
      live_count   <= count;
      obs_status   <= ST_UPD;
      slot_index   <= '0;
      pred_x       <= '0;
      pred_y       <= '0;
      vel_x        <= '0;
      vel_y        <= '0;
      track_radius <= '0;
      last         <= 1'b1;
      case (state)
        S_OBS_FIN: begin
          result_kind <= RK_OBS;
          obs_status  <= st_status;
          slot_index  <= st_slot;
        end
        S_PRN_FIN:   result_kind <= RK_PRUNE;
        S_PRD_EMPTY: result_kind <= RK_EMPTY;
        default: begin
          result_kind  <= RK_TRACK;
          slot_index   <= idx[IDX_W-1:0];
          pred_x       <= px;
          pred_y       <= py;
          vel_x        <= vx;
          vel_y        <= vy;
          track_radius <= e.radius;
          last         <= trk_last;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TRACKS)) else $error("track count above table size");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result_kind == RK_EMPTY) |-> (live_count == '0))
    else $error("empty report with live tracks");

  a_slot_live: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result_kind == RK_TRACK) |-> ({1'b0, slot_index} < live_count))
    else $error("track report beyond live count");
`endif

endmodule
